>>> rtl/heartbeat_liveness_table_assert.svh
// assertion macros for the liveness table checker
// expects clk and arst_n in the scope of use
`ifndef HEARTBEAT_LIVENESS_TABLE_ASSERT_SVH
`define HEARTBEAT_LIVENESS_TABLE_ASSERT_SVH

// checked out of reset only
`define HLT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HLT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/hlt_pkg.sv
// shared types and constants of the heartbeat liveness table
// no dependencies
package hlt_pkg;

	localparam int DEPTH     = 256;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int ID_W      = 32;
	localparam int TIME_W    = 32;
	localparam int BEAT_W    = 32;
	localparam int TMO_W     = 16;
	localparam int SLOT_W    = 8;
	localparam int USER_W    = 2;
	localparam int S_DATA_W  = 64;
	localparam int M_FIELD_W = SLOT_W + BEAT_W + 3 * CNT_W;
	localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_DATA_W - M_FIELD_W;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(30);

	typedef enum logic [1:0] {
		REQ_REGISTER  = 2'd0,
		REQ_HEARTBEAT = 2'd1,
		REQ_QUERY     = 2'd2,
		REQ_SCAN      = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		OUT_DONE      = 2'd0,
		OUT_ADDED     = 2'd1,
		OUT_FULL      = 2'd2,
		OUT_NOT_FOUND = 2'd3
	} outcome_e_t;

	typedef struct packed {
		logic [BEAT_W-1:0] beats;
		logic [TIME_W-1:0] last_seen;
		logic [ID_W-1:0]   id;
	} entry_t;

	typedef struct packed {
		logic ready;
		logic start;
		logic walk;
		logic update;
		logic load;
	} cmd_t;

	typedef struct packed {
		req_e_t req;
		logic   empty;
		logic   hit;
		logic   walk_end;
		logic   out_free;
	} stat_t;

endpackage

>>> rtl/hlt_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module hlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/hlt_ctrl.sv
// sequencer of the liveness table: accept, walk, update, deliver
// depends on hlt_pkg
module hlt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  hlt_pkg::stat_t stat,
	output hlt_pkg::cmd_t  cmd
);
	import hlt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_WALK,
		S_UPDATE,
		S_DONE
	} state_t;

	state_t state_q;
	logic   lookup;

	assign lookup = (stat.req == REQ_REGISTER) || (stat.req == REQ_HEARTBEAT);

	always_comb begin
		cmd.ready  = (state_q == S_IDLE);
		cmd.start  = (state_q == S_IDLE) && s_tvalid;
		cmd.walk   = (state_q == S_WALK);
		cmd.update = (state_q == S_UPDATE);
		cmd.load   = (state_q == S_DONE) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_SETUP;
				end
				S_SETUP: begin
					unique case (stat.req)
						REQ_QUERY: state_q <= S_DONE;
						REQ_SCAN:  state_q <= stat.empty ? S_DONE : S_WALK;
						default:   state_q <= stat.empty ? S_UPDATE : S_WALK;
					endcase
				end
				S_WALK: begin
					if (lookup) begin
						if (stat.hit || stat.walk_end) state_q <= S_UPDATE;
					end else if (stat.walk_end) begin
						state_q <= S_DONE;
					end
				end
				S_UPDATE: state_q <= S_DONE;
				S_DONE: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/hlt_datapath.sv
// datapath of the liveness table: entry ram, active bits, counters, result register
// depends on hlt_pkg and hlt_ram
module hlt_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hlt_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [hlt_pkg::USER_W-1:0]    s_tuser,
	input  logic                          cfg_we,
	input  logic [hlt_pkg::TMO_W-1:0]     cfg_wdata,
	input  hlt_pkg::cmd_t                 cmd,
	output hlt_pkg::stat_t                stat,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hlt_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [hlt_pkg::USER_W-1:0]    m_tuser
);
	import hlt_pkg::*;

	logic [TMO_W-1:0]  timeout_q;
	req_e_t            req_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;

	logic [CNT_W-1:0]  addr_q;
	logic              cmp_valid_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [BEAT_W-1:0] hit_beats_q;

	logic [CNT_W-1:0]  filled_q;
	logic [CNT_W-1:0]  active_q;
	logic [DEPTH-1:0]  alive_q;
	logic [CNT_W-1:0]  expired_q;

	outcome_e_t        res_outcome_q;
	logic [IDX_W-1:0]  res_slot_q;
	logic [BEAT_W-1:0] res_total_q;

	logic              m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;
	logic [USER_W-1:0] m_user_q;

	entry_t            rd_word;
	entry_t            wr_word;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [TIME_W-1:0] age;
	logic              id_match;
	logic              expire;
	logic              last_cmp;
	logic              full;
	logic              upd_alive;
	logic              upd_fill;
	logic              upd_active;
	outcome_e_t        upd_outcome;
	logic [IDX_W-1:0]  upd_slot;
	logic [BEAT_W-1:0] upd_total;

	hlt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_word),
		.raddr(addr_q[IDX_W-1:0]),
		.rdata(rd_word)
	);

	assign age      = now_q - rd_word.last_seen;
	assign last_cmp = cmp_valid_s1 && ((CNT_W'(cmp_idx_s1) + CNT_W'(1)) == filled_q);
	assign id_match = cmp_valid_s1 && (rd_word.id == id_q)
		&& ((req_q == REQ_REGISTER) || (req_q == REQ_HEARTBEAT));
	assign expire   = cmp_valid_s1 && (req_q == REQ_SCAN) && alive_q[cmp_idx_s1]
		&& (age > TIME_W'(timeout_q));
	assign full     = (filled_q == CNT_W'(DEPTH));

	always_comb begin
		stat.req      = req_q;
		stat.empty    = (filled_q == '0);
		stat.hit      = id_match;
		stat.walk_end = last_cmp;
		stat.out_free = !m_valid_q || m_tready;
	end

	always_comb begin
		wr_en       = 1'b0;
		wr_addr     = hit_idx_q;
		wr_word     = '{beats: hit_beats_q, last_seen: now_q, id: id_q};
		upd_alive   = 1'b0;
		upd_fill    = 1'b0;
		upd_active  = 1'b0;
		upd_outcome = OUT_DONE;
		upd_slot    = '0;
		upd_total   = '0;
		unique case (req_q)
			REQ_REGISTER: begin
				if (hit_q) begin
					wr_en      = 1'b1;
					upd_alive  = 1'b1;
					upd_active = !alive_q[hit_idx_q];
					upd_slot   = hit_idx_q;
					upd_total  = hit_beats_q;
				end else if (!full) begin
					wr_en         = 1'b1;
					wr_addr       = filled_q[IDX_W-1:0];
					wr_word.beats = '0;
					upd_alive     = 1'b1;
					upd_fill      = 1'b1;
					upd_active    = 1'b1;
					upd_outcome   = OUT_ADDED;
					upd_slot      = filled_q[IDX_W-1:0];
				end else begin
					upd_outcome = OUT_FULL;
				end
			end
			REQ_HEARTBEAT: begin
				if (hit_q) begin
					wr_en         = 1'b1;
					wr_word.beats = hit_beats_q + BEAT_W'(1);
					upd_slot      = hit_idx_q;
					upd_total     = hit_beats_q + BEAT_W'(1);
				end else begin
					upd_outcome = OUT_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		wr_en = wr_en && cmd.update;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RESET;
			addr_q       <= '0;
			cmp_valid_s1 <= 1'b0;
			hit_q        <= 1'b0;
			filled_q     <= '0;
			active_q     <= '0;
			alive_q      <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			if (cmd.start) begin
				addr_q       <= '0;
				cmp_valid_s1 <= 1'b0;
				hit_q        <= 1'b0;
			end else if (cmd.walk) begin
				cmp_valid_s1 <= (addr_q < filled_q);
				if (addr_q < filled_q) addr_q <= addr_q + CNT_W'(1);
				if (id_match) hit_q <= 1'b1;
				if (expire) begin
					alive_q[cmp_idx_s1] <= 1'b0;
					active_q            <= active_q - CNT_W'(1);
				end
			end
			if (cmd.update) begin
				if (upd_alive) alive_q[wr_addr] <= 1'b1;
				if (upd_fill) filled_q <= filled_q + CNT_W'(1);
				if (upd_active) active_q <= active_q + CNT_W'(1);
			end
			if (cmd.load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q         <= req_e_t'(s_tuser[1:0]);
			id_q          <= s_tdata[ID_W-1:0];
			now_q         <= s_tdata[ID_W +: TIME_W];
			expired_q     <= '0;
			res_outcome_q <= OUT_DONE;
			res_slot_q    <= '0;
			res_total_q   <= '0;
		end
		if (cmd.walk) begin
			cmp_idx_s1 <= addr_q[IDX_W-1:0];
			if (id_match) begin
				hit_idx_q   <= cmp_idx_s1;
				hit_beats_q <= rd_word.beats;
			end
			if (expire) expired_q <= expired_q + CNT_W'(1);
		end
		if (cmd.update) begin
			res_outcome_q <= upd_outcome;
			res_slot_q    <= upd_slot;
			res_total_q   <= upd_total;
		end
		if (cmd.load) begin
			m_user_q <= USER_W'(res_outcome_q);
			m_data_q <= {{M_PAD_W{1'b0}}, active_q, filled_q, expired_q, res_total_q,
				SLOT_W'(res_slot_q)};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

>>> rtl/heartbeat_liveness_table.sv
// top level of the heartbeat liveness table
// depends on hlt_pkg, hlt_ctrl, hlt_datapath (and through it hlt_ram)
//
// requests enter on the s_ stream: tuser carries the request kind, tdata the
// agent id and the current time. each request yields exactly one result beat
// on the m_ stream: tuser carries the outcome, tdata the slot, heartbeat
// count, expired count and the registered and active counts.
// cfg_we writes the timeout in seconds (reset value 30); write only when idle.
// one request is processed at a time. a register, heartbeat or scan walks
// the filled entries one per cycle through the entry ram read port, while
// a query goes straight to its result without a walk. a lookup
// stops at the first matching entry. the result sits in an output register:
// the next request is taken while a result waits, and a stalled receiver
// holds the block only once a second result is ready. reset clears the
// table at once (fill count and active bits) and the output valid, and sets
// the timeout back to its reset value.
module heartbeat_liveness_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [hlt_pkg::S_DATA_W-1:0] s_tdata,  // agent_id, now_seconds
	input  logic [hlt_pkg::USER_W-1:0]   s_tuser,  // req_type
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [hlt_pkg::M_DATA_W-1:0] m_tdata,  // slot, heartbeat_total, expired_now,
	                                               // registered_count, active_count, zero pad
	output logic [hlt_pkg::USER_W-1:0]   m_tuser,  // outcome
	input  logic                         cfg_we,
	input  logic [hlt_pkg::TMO_W-1:0]    cfg_wdata
);
	import hlt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	hlt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.stat    (stat),
		.cmd     (cmd)
	);

	hlt_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	assign s_tready = cmd.ready;

endmodule

>>> rtl/hlt_checker.sv
// port-level checks of the heartbeat liveness table, bound to the top level
// depends on hlt_pkg and heartbeat_liveness_table_assert.svh
`include "heartbeat_liveness_table_assert.svh"

module hlt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [hlt_pkg::M_DATA_W-1:0] m_tdata,
	input logic [hlt_pkg::USER_W-1:0]   m_tuser
);
	import hlt_pkg::*;

	logic [SLOT_W-1:0] slot;
	logic [CNT_W-1:0]  reg_cnt;
	logic [CNT_W-1:0]  act_cnt;

	assign slot    = m_tdata[SLOT_W-1:0];
	assign reg_cnt = m_tdata[SLOT_W + BEAT_W + CNT_W +: CNT_W];
	assign act_cnt = m_tdata[SLOT_W + BEAT_W + 2 * CNT_W +: CNT_W];

	`HLT_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_tvalid, "result valid during reset")
	`HLT_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
		&& $stable(m_tuser), "stalled result changed")
	`HLT_ASSERT(a_active_le_reg, m_tvalid |-> act_cnt <= reg_cnt, "active above registered")
	`HLT_ASSERT(a_added_slot, m_tvalid && (m_tuser == OUT_ADDED)
		|-> slot == SLOT_W'(reg_cnt - CNT_W'(1)), "new entry not at table end")
	`HLT_ASSERT(a_full_count, m_tvalid && (m_tuser == OUT_FULL)
		|-> reg_cnt == CNT_W'(DEPTH), "drop reported while table not full")

endmodule

bind heartbeat_liveness_table hlt_checker u_hlt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
